/* design/fda_pkg.sv */
`timescale 1ns / 1ps
package fda_pkg;

  localparam int VALUE_W        = 32;
  localparam int FL_W           = 5;
  localparam int CHAR_W         = 8;
  localparam int INDEX_W        = 4;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_LENGTH_DEF = 16;

  localparam logic [FL_W-1:0] FIELD_LENGTH_RESET = 5'd7;

  // Register word index within the register map.
  localparam logic REG_FIELD_LENGTH = 1'b0;

  localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;

  typedef enum logic [2:0] {
    SEL_SIGN,
    SEL_INT,
    SEL_POINT,
    SEL_FRAC,
    SEL_TERM
  } char_sel_t;

  typedef struct packed {
    logic                 load;
    logic                 convert;
    logic                 prep;
    logic                 emit;
    char_sel_t            sel;
    logic [INDEX_W-1:0]   index;
    logic                 last;
  } fda_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic int_last;
  } fda_stat_t;

endpackage

/* design/fixed_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Each value is captured, converted to BCD, searched for its leading digit and then
// emitted one character at a time; the binary-to-BCD unit takes one integer bit per
// cycle, then one character leaves per cycle while the output is not stalled. A new
// value is taken only once the last character of the previous one has been emitted.
// Reset: rst_n is synchronous and active low; it returns the sequencer to idle, empties
// the output register and sets field_length to 7.
module fixed_to_decimal_ascii #(
  parameter int FRAC_BITS  = fda_pkg::FRAC_BITS_DEF,
  parameter int MAX_LENGTH = fda_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel: one signed fixed-point value per transfer.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fda_pkg::VALUE_W-1:0]  in_value,
  // Result channel: one character per transfer.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fda_pkg::CHAR_W-1:0]          out_char,
  output logic [fda_pkg::INDEX_W-1:0]         out_char_index,
  output logic                                out_last,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fda_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fda_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fda_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import fda_pkg::*;

  logic [FL_W-1:0] field_length_r;
  fda_cmd_t        cmd;
  fda_stat_t       stat;

  // The port never waits. A write completes in the access cycle. Only the
  // word index bit is decoded, so field_length sits at byte address 0 and
  // anything landing on the next word is dropped.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_length_r <= FIELD_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_FIELD_LENGTH)) begin
      field_length_r <= pwdata[FL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FIELD_LENGTH) begin
      prdata = APB_DATA_W'(field_length_r);
    end
  end

  // The controller sequences each value through capture, binary-to-BCD
  // conversion, a leading-digit search state and then character emission.
  // The field length is sampled at the input transfer, so the whole run of a
  // value uses one consistent length.
  fda_controller #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .field_length (field_length_r),
    .stat         (stat),
    .cmd          (cmd)
  );

  // The datapath holds the sign, the BCD integer digits and the running
  // fraction, and owns the output register. The fraction is multiplied by
  // ten once per fraction digit, so each digit is exact truncation. The
  // output register lets the controller return to idle and take the next
  // value while the terminator still waits for its transfer.
  fda_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_char       (out_char),
    .out_char_index (out_char_index),
    .out_last       (out_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule

/* design/fda_datapath.sv */
`timescale 1ns / 1ps
module fda_datapath #(
  parameter int FRAC_BITS = fda_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [fda_pkg::VALUE_W-1:0] in_value,
  input  fda_pkg::fda_cmd_t                cmd,
  output fda_pkg::fda_stat_t               stat,
  output logic [fda_pkg::CHAR_W-1:0]       out_char,
  output logic [fda_pkg::INDEX_W-1:0]      out_char_index,
  output logic                             out_last,
  output logic                             out_valid,
  input  logic                             out_ready
);
  import fda_pkg::*;

  localparam int IW   = VALUE_W - FRAC_BITS;
  localparam int NDIG = (IW * 301) / 1000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int IDXW = $clog2(NDIG);

  logic                 neg_r;
  logic [IW-1:0]        bin_r, bin_nxt;
  logic [BW-1:0]        bcd_r, bcd_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [IDXW-1:0]      idx_r, idx_nxt;
  logic [CHAR_W-1:0]    char_r;
  logic [INDEX_W-1:0]   index_r;
  logic                 last_r;
  logic                 valid_r;

  logic [VALUE_W-1:0]   mag;
  logic [BW-1:0]        bcd_adj;
  logic [IDXW-1:0]      msd;
  logic [FRAC_BITS+3:0] frac_x10;
  logic [3:0]           int_digit;
  logic [CHAR_W-1:0]    char_nxt;

  assign mag      = in_value[VALUE_W-1] ? VALUE_W'(0) - VALUE_W'(in_value) : VALUE_W'(in_value);
  assign frac_x10 = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0};
  assign int_digit = bcd_r[4*idx_r +: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                   : bcd_r[4*i +: 4];
    end
  end

  // Position of the most significant nonzero digit, zero if all are zero.
  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        msd = IDXW'(i);
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_SIGN:  char_nxt = neg_r ? ASCII_MINUS : ASCII_PLUS;
      SEL_INT:   char_nxt = ASCII_ZERO + {4'd0, int_digit};
      SEL_POINT: char_nxt = ASCII_POINT;
      SEL_FRAC:  char_nxt = ASCII_ZERO + {4'd0, frac_x10[FRAC_BITS+3:FRAC_BITS]};
      SEL_TERM:  char_nxt = ASCII_NUL;
      default:   char_nxt = ASCII_NUL;
    endcase
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    frac_nxt = frac_r;
    idx_nxt  = idx_r;
    if (cmd.load) begin
      bin_nxt  = mag[VALUE_W-1:FRAC_BITS];
      bcd_nxt  = '0;
      frac_nxt = mag[FRAC_BITS-1:0];
    end else if (cmd.convert) begin
      bcd_nxt = {bcd_adj[BW-2:0], bin_r[IW-1]};
      bin_nxt = {bin_r[IW-2:0], 1'b0};
    end else if (cmd.prep) begin
      idx_nxt = msd;
    end else if (cmd.emit) begin
      if (cmd.sel == SEL_INT) begin
        idx_nxt = idx_r - IDXW'(1);
      end
      if (cmd.sel == SEL_FRAC) begin
        frac_nxt = frac_x10[FRAC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    frac_r <= frac_nxt;
    idx_r  <= idx_nxt;
    if (cmd.load) begin
      neg_r <= in_value[VALUE_W-1];
    end
    if (cmd.emit) begin
      char_r  <= char_nxt;
      index_r <= cmd.index;
      last_r  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign stat.slot_free = !valid_r || out_ready;
  assign stat.int_last  = (idx_r == '0);

  assign out_char       = char_r;
  assign out_char_index = index_r;
  assign out_last       = last_r;
  assign out_valid      = valid_r;

endmodule

/* design/fda_controller.sv */
`timescale 1ns / 1ps
module fda_controller #(
  parameter int FRAC_BITS  = fda_pkg::FRAC_BITS_DEF,
  parameter int MAX_LENGTH = fda_pkg::MAX_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fda_pkg::FL_W-1:0]   field_length,
  input  fda_pkg::fda_stat_t         stat,
  output fda_pkg::fda_cmd_t          cmd
);
  import fda_pkg::*;

  localparam int IW   = VALUE_W - FRAC_BITS;
  localparam int CNTW = $clog2(IW);
  localparam int LENW = $clog2(MAX_LENGTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [LENW-1:0] len_r, len_nxt;
  logic [LENW-1:0] k_r, k_nxt;
  char_sel_t       sel_r, sel_nxt;
  logic [LENW-1:0] eff_len;
  logic            is_last;

  always_comb begin
    if (field_length == '0) begin
      eff_len = LENW'(1);
    end else if (32'(field_length) > 32'(MAX_LENGTH)) begin
      eff_len = LENW'(MAX_LENGTH);
    end else begin
      eff_len = LENW'(field_length);
    end
  end

  assign is_last  = (k_r == len_r - LENW'(1));
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    k_nxt       = k_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.sel     = is_last ? SEL_TERM : sel_r;
    cmd.index   = INDEX_W'(k_r);
    cmd.last    = is_last;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNTW'(IW - 1);
          len_nxt   = eff_len;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.convert = 1'b1;
        cnt_nxt     = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        k_nxt     = '0;
        sel_nxt   = SEL_SIGN;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          k_nxt    = k_r + LENW'(1);
          case (sel_r)
            SEL_SIGN:  sel_nxt = SEL_INT;
            SEL_INT:   sel_nxt = stat.int_last ? SEL_POINT : SEL_INT;
            SEL_POINT: sel_nxt = SEL_FRAC;
            default:   sel_nxt = SEL_FRAC;
          endcase
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      len_r   <= LENW'(1);
      k_r     <= '0;
      sel_r   <= SEL_SIGN;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      k_r     <= k_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import fda_pkg::*;

  localparam int FRAC_W    = FRAC_BITS_DEF;
  localparam int FIELD_MAX = MAX_LENGTH_DEF;

  // Byte addresses on the configuration port. Register i sits at 4*i, so the
  // word just above field_length is not mapped to anything.
  localparam logic [APB_ADDR_W-1:0] ADDR_FIELD_LENGTH = {REG_FIELD_LENGTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED     = {~REG_FIELD_LENGTH, 2'b00};

  // Length of the one long receiver hold-off, in clock cycles.
  localparam int FREEZE_CYCLES = 400;

  // One emitted character as the block should present it.
  typedef struct {
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } char_rec_t;

  // Families of random input values.
  typedef enum int {
    VK_ANY,
    VK_FRACTION,
    VK_SMALL,
    VK_DECADE,
    VK_CORNER,
    VK_WHOLE
  } value_kind_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [VALUE_W-1:0]  in_value = '0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [CHAR_W-1:0]          out_char;
  logic [INDEX_W-1:0]         out_char_index;
  logic                       out_last;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]      paddr   = '0;
  logic [APB_DATA_W-1:0]      pwdata  = '0;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;

  // Values waiting to be offered, and characters the block still owes us.
  logic signed [VALUE_W-1:0]  pending_values [$];
  char_rec_t                  expected_chars [$];

  // Our own copy of the field_length register, updated on every completed write to it.
  logic [FL_W-1:0]            field_length_shadow = FIELD_LENGTH_RESET;

  int  mismatch_count = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  bit  freeze_go  = 1'b0;
  logic rx_frozen = 1'b0;

  fixed_to_decimal_ascii i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_char_index (out_char_index),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Only the first few errors are printed in full; the rest are just counted.
  task automatic report_error(input string msg);
    if (mismatch_count < 10) begin
      $display("%s", msg);
    end
    mismatch_count++;
  endtask

  // Works out the characters one value turns into under the current field
  // length and queues them. The sign comes first ('-' for any negative input,
  // even one whose digits are all zero), then the integer digits or a lone
  // '0', then the point and fraction digits from repeated times-ten steps.
  // The last position always carries the terminator, which also cuts off a
  // long integer part. Lengths of 0 act as 1 and lengths past the maximum are
  // clamped to it.
  function automatic void format_field(input logic signed [VALUE_W-1:0] value);
    logic              negative;
    logic [31:0]       magnitude;
    logic [31:0]       int_part;
    logic [63:0]       frac_acc;
    logic [CHAR_W-1:0] text [0:2*FIELD_MAX-1];
    logic [CHAR_W-1:0] digits [0:11];
    int                ndig;
    int                pos;
    int                len;
    char_rec_t         rec;

    negative  = value[VALUE_W-1];
    // The most negative input wraps back onto itself, which read as unsigned
    // is exactly its magnitude.
    magnitude = negative ? (32'd0 - value) : value;
    int_part  = magnitude >> FRAC_W;
    frac_acc  = magnitude & ((64'd1 << FRAC_W) - 1);

    pos = 0;
    text[pos] = negative ? ASCII_MINUS : ASCII_PLUS;
    pos = pos + 1;
    if (int_part == 0) begin
      text[pos] = ASCII_ZERO;
      pos = pos + 1;
    end else begin
      ndig = 0;
      while (int_part != 0) begin
        digits[ndig] = ASCII_ZERO + CHAR_W'(int_part % 10);
        ndig = ndig + 1;
        int_part = int_part / 10;
      end
      while (ndig > 0) begin
        ndig = ndig - 1;
        text[pos] = digits[ndig];
        pos = pos + 1;
      end
    end
    text[pos] = ASCII_POINT;
    pos = pos + 1;
    while (pos < FIELD_MAX) begin
      frac_acc  = frac_acc * 10;
      text[pos] = ASCII_ZERO + CHAR_W'(frac_acc >> FRAC_W);
      pos       = pos + 1;
      frac_acc  = frac_acc & ((64'd1 << FRAC_W) - 1);
    end

    len = int'(field_length_shadow);
    if (len < 1) len = 1;
    if (len > FIELD_MAX) len = FIELD_MAX;

    for (int k = 0; k < len; k++) begin
      rec.last = (k == len - 1);
      rec.ch   = rec.last ? ASCII_NUL : text[k];
      rec.idx  = INDEX_W'(k);
      expected_chars.push_back(rec);
    end
  endfunction

  // Random values lean toward the interesting spots: pure fractions, small
  // integers, decade boundaries where the digit count changes, and the
  // corners of the two's complement range. Fully random words make sure
  // every input bit is exercised both ways.
  function automatic logic signed [VALUE_W-1:0] random_value();
    value_kind_t kind;
    logic [31:0] mag;
    int unsigned decade;

    kind = value_kind_t'($urandom_range(0, 5));
    case (kind)
      VK_ANY: begin
        return $urandom();
      end
      VK_FRACTION: begin
        mag = {16'h0000, 16'($urandom())};
      end
      VK_SMALL: begin
        mag = {16'($urandom_range(0, 99)), 16'($urandom())};
      end
      VK_DECADE: begin
        decade = 1;
        repeat ($urandom_range(0, 4)) decade = decade * 10;
        mag = {16'(decade - $urandom_range(0, 1)),
               ($urandom_range(0, 1) ? 16'h0000 : 16'($urandom()))};
      end
      VK_CORNER: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      default: begin
        mag = {16'($urandom()), 16'h0000};
      end
    endcase
    return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
  endfunction

  // Input side. A value is predicted at the edge where its transfer happens.
  // After each transfer the sender draws how long to stay quiet; with no gap
  // drawn, the next value follows right behind, valid staying high.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap    = 0;
    end else begin
      if (in_valid && in_ready) begin
        format_field(in_value);
        tx_gap = tx_idle_en ? $urandom_range(0, 9) : 0;
      end
      // The payload may only change once the current one has been taken.
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_values.size() != 0) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side. Every character transfer is compared against the oldest
  // expectation, then the receiver draws its own stall before the next one.
  always @(posedge clk) begin
    char_rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_error($sformatf("unexpected char %02h at index %0d (last %0b)",
                                 out_char, out_char_index, out_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch || out_char_index !== want.idx ||
              out_last !== want.last) begin
            report_error($sformatf(
              "char mismatch: expected %02h idx %0d last %0b, got %02h idx %0d last %0b",
              want.ch, want.idx, want.last, out_char, out_char_index, out_last));
          end
        end
        rx_gap = rx_idle_en ? $urandom_range(0, 9) : 0;
      end
      if (rx_frozen) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One long receiver hold-off. The sender keeps offering values meanwhile,
  // so the block backs up and has to stall its input.
  initial begin
    wait (freeze_go);
    @(posedge clk);
    rx_frozen <= 1'b1;
    repeat (FREEZE_CYCLES) @(posedge clk);
    rx_frozen <= 1'b0;
  end

  // Waits until every queued value has been taken and every character has
  // come out, then lets the block settle before returning.
  task automatic wait_drained();
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands at the edge where pready
  // is seen high during access.
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    logic rdy;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_FIELD_LENGTH) begin
      field_length_shadow = data[FL_W-1:0];
    end
    @(negedge clk);
  endtask

  task automatic cfg_read_check(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] want);
    logic                  rdy;
    logic [APB_DATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      got = prdata;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      report_error($sformatf("register read at %0d: expected %08h, got %08h",
                             addr, want, got));
    end
    @(negedge clk);
  endtask

  task automatic set_field_length(input int unsigned len);
    cfg_write(ADDR_FIELD_LENGTH, {27'($urandom()), 5'(len)});
  endtask

  initial begin : stimulus
    int unsigned phase_len;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The register must come out of reset at its documented default.
    cfg_read_check(ADDR_FIELD_LENGTH, APB_DATA_W'(FIELD_LENGTH_RESET));

    // Default length: zero, the smallest steps either side of it (a tiny
    // negative value must still show '-'), whole and half units, and values
    // with long fractions.
    pending_values.push_back(32'h0000_0000);
    pending_values.push_back(32'h0000_0001);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h0001_0000);
    pending_values.push_back(32'hFFFF_0000);
    pending_values.push_back(32'h0000_8000);
    pending_values.push_back(32'h0000_FFFF);
    pending_values.push_back(32'h3039_ADCD);
    pending_values.push_back(32'h270F_FFFF);
    wait_drained();

    // Widest field on the range limits; the most negative value prints as
    // an exact power of two.
    set_field_length(FIELD_MAX);
    cfg_read_check(ADDR_FIELD_LENGTH, APB_DATA_W'(FIELD_MAX));
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Narrowest intended field: the integer part gets cut by the terminator.
    set_field_length(4);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    wait_drained();

    // Lengths below the intended range, down to zero, which acts as a lone
    // terminator.
    set_field_length(0);
    pending_values.push_back(32'h0064_0000);
    wait_drained();
    set_field_length(1);
    pending_values.push_back(32'hFF9C_0000);
    wait_drained();
    set_field_length(2);
    pending_values.push_back(32'h1234_5678);
    wait_drained();
    set_field_length(3);
    pending_values.push_back(32'h8000_0000);
    wait_drained();

    // Lengths above the maximum are clamped.
    set_field_length(FIELD_MAX + 1);
    pending_values.push_back(32'h7FFF_FFFF);
    wait_drained();
    set_field_length(31);
    cfg_read_check(ADDR_FIELD_LENGTH, 32'd31);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h0000_0001);
    wait_drained();

    // A write to an address with no register behind it must change nothing.
    cfg_write(ADDR_UNMAPPED, 32'd5);
    cfg_read_check(ADDR_FIELD_LENGTH, 32'd31);
    pending_values.push_back(32'h0001_8000);
    wait_drained();

    // Random phases, each under its own field length and idling pattern.
    // Phase 0 runs without idling and carries the long receiver hold-off.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       phase_len = FIELD_MAX;
        1:       phase_len = 4;
        2:       phase_len = 9;
        3:       phase_len = 12;
        4:       phase_len = $urandom_range(4, FIELD_MAX);
        5:       phase_len = 5;
        6:       phase_len = $urandom_range(0, 31);
        default: phase_len = FIELD_LENGTH_RESET;
      endcase
      tx_idle_en = (p % 4 == 1) || (p % 4 == 2);
      rx_idle_en = (p % 4 == 1) || (p % 4 == 3);
      set_field_length(phase_len);
      cfg_read_check(ADDR_FIELD_LENGTH, APB_DATA_W'(field_length_shadow));
      for (int n = 0; n < 20; n++) begin
        pending_values.push_back(random_value());
      end
      if (p == 0) begin
        freeze_go = 1'b1;
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
